// ----- design/tpt_pkg.sv -----
`default_nettype none

package tpt_pkg;

    localparam int IN_W       = 16;
    localparam int OUT_W      = 16;
    localparam int COLOR_W    = 32;
    localparam int THICK_W    = 12;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // segment arithmetic
    localparam int MUL_W      = 24;
    localparam int NORM_BITS  = 24;
    localparam int ROOT_SHIFT = 14;
    localparam int ROOT_W     = 64;
    localparam int ROOT_STEPS = 32;
    localparam int LEN_W      = 32;
    localparam int QBITS      = 16;
    localparam int QW         = QBITS + 1;
    localparam int REM_W      = 50;
    localparam int DASH_W     = 22;

    localparam logic [0:0] ACT_ADD   = 1'b0;
    localparam logic [0:0] ACT_CLOSE = 1'b1;

    localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STS_CLOSED    = 2'd1;
    localparam logic [STATUS_W-1:0] STS_NO_START  = 2'd2;
    localparam logic [STATUS_W-1:0] STS_TRUNCATED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_THICKNESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DASHED    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR     = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_NORM,
        ST_SQX,
        ST_SQY,
        ST_RINIT,
        ST_ROOT,
        ST_MUL,
        ST_DINIT,
        ST_DIV,
        ST_SPAN,
        ST_PATH,
        ST_QUAD,
        ST_DASH,
        ST_EMIT,
        ST_FINISH
    } tpt_state_t;

    typedef enum logic [2:0] {
        TK_ERR,
        TK_Q1,
        TK_Q2,
        TK_J1,
        TK_J2,
        TK_C1,
        TK_C2
    } tpt_tri_t;

endpackage

`default_nettype wire

// ----- design/thick_polyline_triangulator_unit.sv -----
// a first point is only stored and gives no triangle; a segment runs check, normalize
//   (one shift per step while too wide), squares, 32 square root steps, then four
//   divisions for the normal and step (multiply, init, 16 quotient bits each), span,
//   path, quad or dashes, finish; one transaction at a time, s_ready only in idle; a
//   zero-length segment skips the divisions; emit holds while the output stalls; reset:
//   aresetn synchronous active low, thickness 16, solid, white, flags clear
`default_nettype none

module thick_polyline_triangulator_unit #(
    parameter int MAX_DASHES = 16,
    parameter int COORD_BITS = 16
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [tpt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [tpt_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire                              s_action,
    input  wire  signed [tpt_pkg::IN_W-1:0]  s_point_x,
    input  wire  signed [tpt_pkg::IN_W-1:0]  s_point_y,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic signed [tpt_pkg::OUT_W-1:0] m_corner_a_x,
    output logic signed [tpt_pkg::OUT_W-1:0] m_corner_a_y,
    output logic signed [tpt_pkg::OUT_W-1:0] m_corner_b_x,
    output logic signed [tpt_pkg::OUT_W-1:0] m_corner_b_y,
    output logic signed [tpt_pkg::OUT_W-1:0] m_corner_c_x,
    output logic signed [tpt_pkg::OUT_W-1:0] m_corner_c_y,
    output logic [tpt_pkg::COLOR_W-1:0]      m_color_out,
    output logic [tpt_pkg::STATUS_W-1:0]     m_status,
    output logic                             m_last_of_run
);
    import tpt_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int XW  = ((CB > NORM_BITS) ? CB : NORM_BITS) + 2;
    localparam int SW  = $clog2(XW);
    localparam int DW  = LEN_W + XW;
    localparam int NW  = $clog2(MAX_DASHES + 1);
    localparam logic signed [XW-1:0] CMAX = {{(XW-CB+1){1'b0}}, {(CB-1){1'b1}}};
    localparam logic signed [XW-1:0] CMIN = ~CMAX;

    function automatic logic signed [CB-1:0] sat(input logic signed [XW-1:0] v);
        logic signed [CB-1:0] r;
        if (v > CMAX) r = CMAX[CB-1:0];
        else if (v < CMIN) r = CMIN[CB-1:0];
        else r = v[CB-1:0];
        return r;
    endfunction

    function automatic logic signed [CB-1:0] vadd(input logic signed [CB-1:0] a,
                                                  input logic signed [QW-1:0] b);
        return sat(XW'(a) + XW'(b));
    endfunction

    function automatic logic signed [CB-1:0] vsub(input logic signed [CB-1:0] a,
                                                  input logic signed [QW-1:0] b);
        return sat(XW'(a) - XW'(b));
    endfunction

    function automatic logic signed [OUT_W-1:0] to_out(input logic signed [CB-1:0] a);
        logic signed [XW-1:0] e;
        e = XW'(a);
        return e[OUT_W-1:0];
    endfunction

    tpt_state_t state_reg, state_next;
    tpt_tri_t   kind_reg;

    logic [THICK_W-1:0] thick_reg;
    logic               dashed_reg;
    logic [COLOR_W-1:0] color_reg;

    logic started_reg, left_reg, right_reg, closed_reg;
    logic signed [CB-1:0] start_x_reg, start_y_reg, prev_x_reg, prev_y_reg;
    logic signed [CB-1:0] stl_x_reg, stl_y_reg, sbl_x_reg, sbl_y_reg;
    logic signed [CB-1:0] ptr_x_reg, ptr_y_reg, pbr_x_reg, pbr_y_reg;

    logic                 act_reg;
    logic signed [CB-1:0] pin_x_reg, pin_y_reg, tgt_x_reg, tgt_y_reg;
    logic [XW-1:0]        ax_reg, ay_reg;
    logic                 dxn_reg, dyn_reg;
    logic [SW-1:0]        shift_reg;
    logic [2*MUL_W-1:0]   prod_reg, sum_reg;
    logic [ROOT_W-1:0]    root_rem_reg, root_res_reg, root_bit_reg;
    logic [4:0]           step_cnt_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [1:0]           div_k_reg;
    logic [REM_W-1:0]     div_rem_reg, div_den_reg;
    logic [QBITS-1:0]     div_q_reg;
    logic signed [QW-1:0] hx_reg, hy_reg, sx_reg, sy_reg;
    logic [DW-1:0]        dist_reg, drawn_reg;
    logic [NW-1:0]        n_reg;
    logic                 trunc_reg, dash_last_reg;
    logic signed [CB-1:0] cur_x_reg, cur_y_reg;
    logic signed [CB-1:0] tl_x_reg, tl_y_reg, bl_x_reg, bl_y_reg;
    logic signed [CB-1:0] tr_x_reg, tr_y_reg, br_x_reg, br_y_reg;
    logic                 m_valid_reg;

    logic [DASH_W-1:0] dash;
    assign dash = (DASH_W'(thick_reg) << 9) + (DASH_W'(thick_reg) << 7);

    // shared multiplier
    logic [MUL_W-1:0] mul_a, mul_b;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQX: begin
                mul_a = ax_reg[MUL_W-1:0];
                mul_b = ax_reg[MUL_W-1:0];
            end
            ST_SQY: begin
                mul_a = ay_reg[MUL_W-1:0];
                mul_b = ay_reg[MUL_W-1:0];
            end
            ST_MUL: begin
                mul_a = (div_k_reg == 2'd1 || div_k_reg == 2'd2) ?
                        ax_reg[MUL_W-1:0] : ay_reg[MUL_W-1:0];
                mul_b = MUL_W'(thick_reg);
            end
            ST_SPAN: begin
                mul_a = MUL_W'(dash);
                mul_b = MUL_W'(2 * MAX_DASHES);
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // input capture and segment difference
    logic signed [CB-1:0] tgt_x, tgt_y;
    logic signed [XW-1:0] dx, dy;
    assign tgt_x = act_reg ? start_x_reg : pin_x_reg;
    assign tgt_y = act_reg ? start_y_reg : pin_y_reg;
    assign dx = XW'(tgt_x) - XW'(prev_x_reg);
    assign dy = XW'(tgt_y) - XW'(prev_y_reg);

    logic too_big;
    assign too_big = (|ax_reg[XW-1:NORM_BITS]) || (|ay_reg[XW-1:NORM_BITS]);

    // square root step
    logic [ROOT_W-1:0] root_try, root_res_next;
    logic              root_ge;
    assign root_try = root_res_reg + root_bit_reg;
    assign root_ge = root_rem_reg >= root_try;
    assign root_res_next = root_ge ? ((root_res_reg >> 1) + root_bit_reg) : (root_res_reg >> 1);

    // divider operands
    logic [REM_W-1:0] div_num, div_den, div_half;
    logic             div_ge;
    logic             div_neg;
    logic [QBITS-1:0] div_q_next;
    always_comb begin
        if (div_k_reg[1]) begin
            div_num  = (REM_W'(prod_reg) << 9) + (REM_W'(prod_reg) << 7);
            div_den  = REM_W'(len_reg);
            div_half = REM_W'(len_reg >> 1);
        end else begin
            div_num  = REM_W'(prod_reg) << 7;
            div_den  = REM_W'(len_reg) << 1;
            div_half = REM_W'(len_reg);
        end
        case (div_k_reg)
            2'd0: div_neg = !dyn_reg;
            2'd1: div_neg = dxn_reg;
            2'd2: div_neg = dxn_reg;
            default: div_neg = dyn_reg;
        endcase
    end
    assign div_ge = div_rem_reg >= div_den_reg;
    assign div_q_next = {div_q_reg[QBITS-2:0], div_ge};

    logic signed [QW-1:0] div_res;
    assign div_res = div_neg ? -QW'({1'b0, div_q_next}) : QW'({1'b0, div_q_next});

    // quad corners around the current piece
    logic signed [CB-1:0] nxt_x, nxt_y, p1_x, p1_y, p2_x, p2_y;
    logic [DW-1:0]        drawn_half, drawn_full;
    assign drawn_half = drawn_reg + DW'(dash);
    assign drawn_full = drawn_half + DW'(dash);
    assign nxt_x = (drawn_half < dist_reg) ? vadd(cur_x_reg, sx_reg) : tgt_x_reg;
    assign nxt_y = (drawn_half < dist_reg) ? vadd(cur_y_reg, sy_reg) : tgt_y_reg;
    assign p1_x = (state_reg == ST_DASH) ? cur_x_reg : prev_x_reg;
    assign p1_y = (state_reg == ST_DASH) ? cur_y_reg : prev_y_reg;
    assign p2_x = (state_reg == ST_DASH) ? nxt_x : tgt_x_reg;
    assign p2_y = (state_reg == ST_DASH) ? nxt_y : tgt_y_reg;

    logic signed [CB-1:0] qtl_x, qtl_y, qbl_x, qbl_y, qtr_x, qtr_y, qbr_x, qbr_y;
    assign qbl_x = vadd(p1_x, hx_reg);
    assign qbl_y = vadd(p1_y, hy_reg);
    assign qtl_x = vsub(p1_x, hx_reg);
    assign qtl_y = vsub(p1_y, hy_reg);
    assign qbr_x = vadd(p2_x, hx_reg);
    assign qbr_y = vadd(p2_y, hy_reg);
    assign qtr_x = vsub(p2_x, hx_reg);
    assign qtr_y = vsub(p2_y, hy_reg);

    logic dash_more;
    assign dash_more = (drawn_reg < dist_reg) && (n_reg < NW'(MAX_DASHES));

    logic slot_free;
    assign slot_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_CHECK;
            ST_CHECK: begin
                if (closed_reg || (act_reg == ACT_CLOSE && !started_reg))
                    state_next = ST_EMIT;
                else if (!started_reg)
                    state_next = ST_IDLE;
                else
                    state_next = ST_NORM;
            end
            ST_NORM: if (!too_big) state_next = ST_SQX;
            ST_SQX: state_next = ST_SQY;
            ST_SQY: state_next = ST_RINIT;
            ST_RINIT: state_next = ST_ROOT;
            ST_ROOT: begin
                if (step_cnt_reg == 5'(ROOT_STEPS - 1))
                    state_next = (root_res_next == '0) ? ST_SPAN : ST_MUL;
            end
            ST_MUL: state_next = ST_DINIT;
            ST_DINIT: state_next = ST_DIV;
            ST_DIV: begin
                if (step_cnt_reg == 5'(QBITS - 1))
                    state_next = (div_k_reg == 2'd3) ? ST_SPAN : ST_MUL;
            end
            ST_SPAN: state_next = ST_PATH;
            ST_PATH: state_next = (dashed_reg && dist_reg != '0) ? ST_DASH : ST_QUAD;
            ST_QUAD: state_next = dashed_reg ? ST_FINISH : ST_EMIT;
            ST_DASH: state_next = ST_EMIT;
            ST_EMIT: begin
                if (slot_free) begin
                    case (kind_reg)
                        TK_ERR: state_next = ST_IDLE;
                        TK_Q2: begin
                            if (dashed_reg) state_next = dash_more ? ST_DASH : ST_FINISH;
                            else state_next = right_reg ? ST_EMIT : ST_FINISH;
                        end
                        TK_J2: state_next = ST_FINISH;
                        TK_C2: state_next = ST_IDLE;
                        default: state_next = ST_EMIT;
                    endcase
                end
            end
            ST_FINISH: state_next = act_reg ? ST_EMIT : ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // handshake outputs and triangle selection
    logic signed [CB-1:0] ta_x, ta_y, tb_x, tb_y, tc_x, tc_y;
    logic                 t_last;
    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        cfg_ready = 1'b1;
        ta_x = '0; ta_y = '0; tb_x = '0; tb_y = '0; tc_x = '0; tc_y = '0;
        t_last = 1'b0;
        case (kind_reg)
            TK_Q1: begin
                ta_x = bl_x_reg; ta_y = bl_y_reg; tb_x = tl_x_reg; tb_y = tl_y_reg;
                tc_x = tr_x_reg; tc_y = tr_y_reg;
            end
            TK_Q2: begin
                ta_x = tr_x_reg; ta_y = tr_y_reg; tb_x = br_x_reg; tb_y = br_y_reg;
                tc_x = bl_x_reg; tc_y = bl_y_reg;
                t_last = dashed_reg ? dash_last_reg : (!right_reg && !act_reg);
            end
            TK_J1: begin
                ta_x = ptr_x_reg; ta_y = ptr_y_reg; tb_x = tl_x_reg; tb_y = tl_y_reg;
                tc_x = prev_x_reg; tc_y = prev_y_reg;
            end
            TK_J2: begin
                ta_x = prev_x_reg; ta_y = prev_y_reg; tb_x = bl_x_reg; tb_y = bl_y_reg;
                tc_x = pbr_x_reg; tc_y = pbr_y_reg;
                t_last = !act_reg;
            end
            TK_C1: begin
                ta_x = ptr_x_reg; ta_y = ptr_y_reg; tb_x = stl_x_reg; tb_y = stl_y_reg;
                tc_x = start_x_reg; tc_y = start_y_reg;
            end
            TK_C2: begin
                ta_x = start_x_reg; ta_y = start_y_reg; tb_x = sbl_x_reg; tb_y = sbl_y_reg;
                tc_x = pbr_x_reg; tc_y = pbr_y_reg;
                t_last = 1'b1;
            end
            default: begin
                t_last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            kind_reg    <= TK_ERR;
            thick_reg   <= THICK_W'(16);
            dashed_reg  <= 1'b0;
            color_reg   <= '1;
            started_reg <= 1'b0;
            left_reg    <= 1'b0;
            right_reg   <= 1'b0;
            closed_reg  <= 1'b0;
            start_x_reg <= '0;
            start_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_THICKNESS: thick_reg <= cfg_data[THICK_W-1:0];
                    CFG_DASHED: dashed_reg <= cfg_data[0];
                    CFG_COLOR: color_reg <= cfg_data[COLOR_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_EMIT && slot_free) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_CHECK: begin
                    if (closed_reg || (act_reg == ACT_CLOSE && !started_reg)) begin
                        kind_reg <= TK_ERR;
                    end else if (!started_reg) begin
                        start_x_reg <= pin_x_reg;
                        start_y_reg <= pin_y_reg;
                        prev_x_reg  <= pin_x_reg;
                        prev_y_reg  <= pin_y_reg;
                        started_reg <= 1'b1;
                    end
                end
                ST_QUAD, ST_DASH: begin
                    kind_reg <= TK_Q1;
                    left_reg <= 1'b1;
                end
                ST_EMIT: begin
                    if (slot_free) begin
                        case (kind_reg)
                            TK_Q1: kind_reg <= TK_Q2;
                            TK_Q2: if (!dashed_reg && right_reg) kind_reg <= TK_J1;
                            TK_J1: kind_reg <= TK_J2;
                            TK_C1: kind_reg <= TK_C2;
                            TK_C2: closed_reg <= 1'b1;
                            default: ;
                        endcase
                    end
                end
                ST_FINISH: begin
                    prev_x_reg <= tgt_x_reg;
                    prev_y_reg <= tgt_y_reg;
                    right_reg  <= 1'b1;
                    kind_reg   <= TK_C1;
                end
                default: ;
            endcase
        end
    end

    // datapath, no reset needed
    always_ff @(posedge aclk) begin
        prod_reg <= (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);
        if (state_reg == ST_EMIT && slot_free) begin
            m_corner_a_x <= to_out(ta_x);
            m_corner_a_y <= to_out(ta_y);
            m_corner_b_x <= to_out(tb_x);
            m_corner_b_y <= to_out(tb_y);
            m_corner_c_x <= to_out(tc_x);
            m_corner_c_y <= to_out(tc_y);
            m_last_of_run <= t_last;
            if (kind_reg == TK_ERR) begin
                m_color_out <= '0;
                m_status    <= closed_reg ? STS_CLOSED : STS_NO_START;
            end else begin
                m_color_out <= color_reg;
                m_status    <= trunc_reg ? STS_TRUNCATED : STS_OK;
            end
        end
        case (state_reg)
            ST_IDLE: begin
                act_reg   <= s_action;
                pin_x_reg <= sat(XW'(s_point_x));
                pin_y_reg <= sat(XW'(s_point_y));
            end
            ST_CHECK: begin
                tgt_x_reg <= tgt_x;
                tgt_y_reg <= tgt_y;
                dxn_reg   <= dx[XW-1];
                dyn_reg   <= dy[XW-1];
                ax_reg    <= dx[XW-1] ? -dx : dx;
                ay_reg    <= dy[XW-1] ? -dy : dy;
                shift_reg <= '0;
                trunc_reg <= 1'b0;
            end
            ST_NORM: begin
                if (too_big) begin
                    ax_reg    <= ax_reg >> 1;
                    ay_reg    <= ay_reg >> 1;
                    shift_reg <= shift_reg + SW'(1);
                end
            end
            ST_SQY: sum_reg <= prod_reg;
            ST_RINIT: begin
                root_rem_reg <= (ROOT_W'(sum_reg) + ROOT_W'(prod_reg)) << ROOT_SHIFT;
                root_res_reg <= '0;
                root_bit_reg <= ROOT_W'(1) << (ROOT_W - 2);
                step_cnt_reg <= '0;
            end
            ST_ROOT: begin
                if (root_ge) root_rem_reg <= root_rem_reg - root_try;
                root_res_reg <= root_res_next;
                root_bit_reg <= root_bit_reg >> 2;
                step_cnt_reg <= step_cnt_reg + 5'd1;
                len_reg      <= root_res_next[LEN_W-1:0];
                div_k_reg    <= '0;
                hx_reg <= '0;
                hy_reg <= '0;
                sx_reg <= '0;
                sy_reg <= '0;
            end
            ST_DINIT: begin
                div_rem_reg  <= div_num + div_half;
                div_den_reg  <= div_den << (QBITS - 1);
                div_q_reg    <= '0;
                step_cnt_reg <= '0;
            end
            ST_DIV: begin
                if (div_ge) div_rem_reg <= div_rem_reg - div_den_reg;
                div_den_reg  <= div_den_reg >> 1;
                div_q_reg    <= div_q_next;
                step_cnt_reg <= step_cnt_reg + 5'd1;
                if (step_cnt_reg == 5'(QBITS - 1)) begin
                    div_k_reg <= div_k_reg + 2'd1;
                    case (div_k_reg)
                        2'd0: hx_reg <= div_res;
                        2'd1: hy_reg <= div_res;
                        2'd2: sx_reg <= div_res;
                        default: sy_reg <= div_res;
                    endcase
                end
            end
            ST_SPAN: dist_reg <= DW'(len_reg) << shift_reg;
            ST_PATH: begin
                trunc_reg <= dashed_reg && (dist_reg > DW'(prod_reg));
                cur_x_reg <= prev_x_reg;
                cur_y_reg <= prev_y_reg;
                drawn_reg <= '0;
                n_reg     <= '0;
            end
            ST_QUAD, ST_DASH: begin
                tl_x_reg <= qtl_x; tl_y_reg <= qtl_y;
                bl_x_reg <= qbl_x; bl_y_reg <= qbl_y;
                tr_x_reg <= qtr_x; tr_y_reg <= qtr_y;
                br_x_reg <= qbr_x; br_y_reg <= qbr_y;
                if (!left_reg) begin
                    stl_x_reg <= qtl_x; stl_y_reg <= qtl_y;
                    sbl_x_reg <= qbl_x; sbl_y_reg <= qbl_y;
                end
                if (state_reg == ST_DASH) begin
                    cur_x_reg <= vadd(nxt_x, sx_reg);
                    cur_y_reg <= vadd(nxt_y, sy_reg);
                    drawn_reg <= drawn_full;
                    n_reg     <= n_reg + NW'(1);
                    dash_last_reg <= !act_reg &&
                        ((drawn_full >= dist_reg) || (n_reg + NW'(1) >= NW'(MAX_DASHES)));
                end
            end
            ST_FINISH: begin
                ptr_x_reg <= tr_x_reg; ptr_y_reg <= tr_y_reg;
                pbr_x_reg <= br_x_reg; pbr_y_reg <= br_y_reg;
            end
            default: ;
        endcase
    end

    assign m_valid = m_valid_reg;

    // checks
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

    a_closed_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        closed_reg |=> closed_reg)
        else $error("closed flag dropped");

    a_dash_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DASH |-> n_reg < NW'(MAX_DASHES))
        else $error("dash count over cap");

    a_left_needs_start: assert property (@(posedge aclk) disable iff (!aresetn)
        left_reg |-> started_reg)
        else $error("start corners without start point");

    a_trunc_dashed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STS_TRUNCATED |-> dashed_reg)
        else $error("truncation flagged on solid line");

endmodule

`default_nettype wire
